@@ src/ugsi_pkg.sv @@
package ugsi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 5;
  localparam int HALF_TURN   = 1800;
  localparam int FULL_TURN   = 3600;
  localparam int WRAP_BIAS   = FULL_TURN * 20;
  localparam int MOD_STEPS   = 6;
  localparam int DIV1_STEPS  = 31;
  localparam int DIV2_STEPS  = 17;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [2:0] REG_START    = 3'd0;
  localparam logic [2:0] REG_INTERVAL = 3'd1;
  localparam logic [2:0] REG_COUNT    = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_FALLBACK = 3'd4;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_ANGLE    = 2'd2;

  localparam logic [1:0] ST_BLEND    = 2'd0;
  localparam logic [1:0] ST_HOLD     = 2'd1;
  localparam logic [1:0] ST_FALLBACK = 2'd2;

  // After the index stage CLS_DIVIDE marks a beat that is blended.
  typedef enum logic [1:0] {
    CLS_WRITE    = 2'd0,
    CLS_FALLBACK = 2'd1,
    CLS_HOLD     = 2'd2,
    CLS_DIVIDE   = 2'd3
  } cls_e;

  typedef struct packed {
    logic [31:0]        start;
    logic [30:0]        interval;
    logic [CNT_W-1:0]   count;
    logic [1:0]         mode;
    logic signed [16:0] fallback;
  } cfg_t;

  typedef struct packed {
    cls_e             cls;
    logic [IDX_W-1:0] idx;
    logic [15:0]      word;
    logic [30:0]      offset;
  } item_t;

  function automatic logic [31:0] div_step(input logic [30:0] rem, input logic nbit,
                                           input logic [30:0] den);
    logic [31:0] t;
    logic [31:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[30:0], 1'b1};
    end
    return {t[30:0], 1'b0};
  endfunction

endpackage

@@ src/ugsi_if.sv @@
interface ugsi_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  sample_index;
  logic [15:0] sample_word;
  logic [31:0] query_time;

  modport source (output valid, command, sample_index, sample_word, query_time,
                  input ready);
  modport sink   (input valid, command, sample_index, sample_word, query_time,
                  output ready);
endinterface

interface ugsi_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] interp_value;
  logic [1:0]         interp_status;

  modport source (output valid, interp_value, interp_status, input ready);
  modport sink   (input valid, interp_value, interp_status, output ready);
endinterface

@@ src/uniform_grid_sample_interpolator.sv @@
// Uniform-grid sample interpolator.
// The input channel carries two kinds of beat. A write beat (command 0) stores
// sample_word in table entry sample_index and gives no result. A query beat
// (command 1) gives one result beat with the value interpolated at query_time
// and a status: blended, held at the first or last sample, or fallback.
// Beats are handled strictly in order, so a query sees every earlier write.
// Configuration must be written through the APB port while the block is idle;
// the block itself does not enforce this. Query results pass the 31-step
// index divider and the 17-step fraction divider, one step per stage. One beat
// is accepted every cycle unless the front register is held by a full queue.
// When the receiver stalls, the back pipeline freezes and the four-entry queue
// between front and back fills before input ready falls.
// Reset clears the registers to their defaults and empties the pipeline; the
// sample table is not cleared and must be written before it is read.
module uniform_grid_sample_interpolator
  import ugsi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ugsi_in_if.sink           in_i,
  ugsi_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg_q;
  logic  push;
  logic  pop;
  logic  full;
  logic  fifo_vld;
  item_t push_item;
  item_t pop_item;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start    <= '0;
      cfg_q.interval <= 31'd1;
      cfg_q.count    <= '0;
      cfg_q.mode     <= MODE_UNSIGNED;
      cfg_q.fallback <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_START:    cfg_q.start    <= pwdata;
        REG_INTERVAL: cfg_q.interval <= pwdata[30:0];
        REG_COUNT:    cfg_q.count    <= pwdata[CNT_W-1:0];
        REG_MODE:     cfg_q.mode     <= pwdata[1:0];
        REG_FALLBACK: cfg_q.fallback <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_START:    prdata = cfg_q.start;
      REG_INTERVAL: prdata = {1'b0, cfg_q.interval};
      REG_COUNT:    prdata = 32'(cfg_q.count);
      REG_MODE:     prdata = 32'(cfg_q.mode);
      REG_FALLBACK: prdata = 32'(cfg_q.fallback);
      default:      prdata = '0;
    endcase
  end

  ugsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  ugsi_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .vld_o  (fifo_vld),
    .full_o (full),
    .item_o (pop_item)
  );

  ugsi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_vld_i  (fifo_vld),
    .fifo_item_i (pop_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

@@ src/ugsi_front.sv @@
module ugsi_front
  import ugsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  ugsi_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic  fq_vld_q;
  item_t fq_item_q;
  item_t fq_item_d;
  logic  [31:0] diff;
  logic  accept;

  assign in_i.ready = !fq_vld_q || !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = fq_vld_q && !full_i;
  assign item_o     = fq_item_q;

  always_comb begin
    diff             = in_i.query_time - cfg_i.start;
    fq_item_d.idx    = in_i.sample_index;
    fq_item_d.word   = in_i.sample_word;
    fq_item_d.offset = diff[30:0];
    if (!in_i.command) begin
      fq_item_d.cls = CLS_WRITE;
    end else if (cfg_i.count == '0) begin
      fq_item_d.cls = CLS_FALLBACK;
    end else if (cfg_i.interval == '0 || diff[31]) begin
      fq_item_d.cls = CLS_HOLD;
    end else begin
      fq_item_d.cls = CLS_DIVIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fq_vld_q <= 1'b0;
    end else if (accept) begin
      fq_vld_q <= 1'b1;
    end else if (push_o) begin
      fq_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fq_item_q <= fq_item_d;
    end
  end

endmodule

@@ src/ugsi_fifo.sv @@
module ugsi_fifo
  import ugsi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  vld_o,
  output logic  full_o,
  output item_t item_o
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign vld_o  = cnt_q != '0;
  assign full_o = cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/ugsi_back.sv @@
module ugsi_back
  import ugsi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     fifo_vld_i,
  input  item_t    fifo_item_i,
  output logic     pop_o,
  ugsi_out_if.source out_o
);

  logic adv;

  // Index divider.
  logic [DIV1_STEPS:0] d1_vld_q;
  cls_e                d1_cls_q  [DIV1_STEPS+1];
  logic [IDX_W-1:0]    d1_idx_q  [DIV1_STEPS+1];
  logic [15:0]         d1_word_q [DIV1_STEPS+1];
  logic [30:0]         d1_rem_q  [DIV1_STEPS+1];
  logic [30:0]         d1_dvd_q  [DIV1_STEPS+1];
  logic [31:0]         d1_step   [DIV1_STEPS];

  // Index stage, table stage and difference stage.
  logic             a_vld_q;
  cls_e             a_cls_q;
  logic [IDX_W-1:0] a_addr_q;
  logic [15:0]      a_word_q;
  logic [30:0]      a_num_q;
  cls_e             a_cls_d;
  logic [IDX_W-1:0] a_addr_d;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] lastk;

  logic [15:0] table_q [TABLE_DEPTH];
  logic        m_vld_q;
  cls_e        m_cls_q;
  logic [30:0] m_num_q;
  logic [15:0] rd_a_q;
  logic [15:0] rd_b_q;

  logic signed [17:0] sa;
  logic signed [17:0] sb;
  logic signed [17:0] dif;
  logic               dd_vld_q;
  cls_e               dd_cls_q;
  logic signed [17:0] dd_a_q;
  logic               dd_neg_q;
  logic [16:0]        dd_mag_q;
  logic [30:0]        dd_num_q;
  logic [47:0]        prod;

  // Fraction divider.
  logic [DIV2_STEPS:0] e_vld_q;
  cls_e                e_cls_q [DIV2_STEPS+1];
  logic signed [17:0]  e_a_q   [DIV2_STEPS+1];
  logic [DIV2_STEPS:0] e_neg_q;
  logic [30:0]         e_rem_q [DIV2_STEPS+1];
  logic [16:0]         e_dvd_q [DIV2_STEPS+1];
  logic [31:0]         e_step  [DIV2_STEPS];

  logic               f_vld_q;
  cls_e               f_cls_q;
  logic signed [17:0] f_a_q;
  logic signed [18:0] f_x_q;
  logic [17:0]        f_y_q;
  logic signed [18:0] qs;
  logic signed [18:0] x;

  logic [17:0]        mod_v;
  logic               out_vld_q;
  logic signed [16:0] out_value_q;
  logic [1:0]         out_status_q;
  logic signed [16:0] out_value_d;
  logic [1:0]         out_status_d;

  assign adv   = !out_vld_q || out_o.ready;
  assign pop_o = adv && fifo_vld_i;

  always_comb begin
    for (int s = 0; s < DIV1_STEPS; s++) begin
      d1_step[s] = div_step(d1_rem_q[s], d1_dvd_q[s][DIV1_STEPS-1], cfg_i.interval);
    end
    for (int s = 0; s < DIV2_STEPS; s++) begin
      e_step[s] = div_step(e_rem_q[s], e_dvd_q[s][DIV2_STEPS-1], cfg_i.interval);
    end
  end

  always_comb begin
    cnt   = (cfg_i.count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cfg_i.count;
    lastk = cnt - 1'b1;
    a_cls_d  = d1_cls_q[DIV1_STEPS];
    a_addr_d = d1_idx_q[DIV1_STEPS];
    case (d1_cls_q[DIV1_STEPS])
      CLS_HOLD: a_addr_d = '0;
      CLS_DIVIDE: begin
        if (d1_dvd_q[DIV1_STEPS] >= 31'(lastk)) begin
          a_cls_d  = CLS_HOLD;
          a_addr_d = lastk[IDX_W-1:0];
        end else begin
          a_addr_d = d1_dvd_q[DIV1_STEPS][IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cfg_i.mode == MODE_SIGNED) begin
      sa = 18'(signed'(rd_a_q));
      sb = 18'(signed'(rd_b_q));
    end else begin
      sa = signed'({2'b00, rd_a_q});
      sb = signed'({2'b00, rd_b_q});
    end
    dif = sb - sa;
    if (cfg_i.mode == MODE_ANGLE) begin
      if (dif > 18'sd1800) begin
        dif = dif - 18'(FULL_TURN);
      end else if (dif < -18'sd1800) begin
        dif = dif + 18'(FULL_TURN);
      end
    end
  end

  assign prod = 48'(dd_mag_q) * 48'(dd_num_q);

  always_comb begin
    qs = e_neg_q[DIV2_STEPS] ? -signed'({2'b00, e_dvd_q[DIV2_STEPS]})
                             : signed'({2'b00, e_dvd_q[DIV2_STEPS]});
    x  = 19'(e_a_q[DIV2_STEPS]) + qs;
  end

  always_comb begin
    mod_v = f_y_q;
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      if (mod_v >= 18'(FULL_TURN * (1 << j))) begin
        mod_v = mod_v - 18'(FULL_TURN * (1 << j));
      end
    end
    case (f_cls_q)
      CLS_FALLBACK: begin
        out_value_d  = cfg_i.fallback;
        out_status_d = ST_FALLBACK;
      end
      CLS_HOLD: begin
        out_value_d  = f_a_q[16:0];
        out_status_d = ST_HOLD;
      end
      default: begin
        out_value_d  = (cfg_i.mode == MODE_ANGLE) ? mod_v[16:0] : f_x_q[16:0];
        out_status_d = ST_BLEND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q  <= '0;
      a_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      dd_vld_q  <= 1'b0;
      e_vld_q   <= '0;
      f_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      d1_vld_q  <= {d1_vld_q[DIV1_STEPS-1:0], fifo_vld_i};
      a_vld_q   <= d1_vld_q[DIV1_STEPS];
      m_vld_q   <= a_vld_q;
      dd_vld_q  <= m_vld_q;
      e_vld_q   <= {e_vld_q[DIV2_STEPS-1:0], dd_vld_q};
      f_vld_q   <= e_vld_q[DIV2_STEPS];
      out_vld_q <= f_vld_q && (f_cls_q != CLS_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_cls_q[0]  <= fifo_item_i.cls;
      d1_idx_q[0]  <= fifo_item_i.idx;
      d1_word_q[0] <= fifo_item_i.word;
      d1_rem_q[0]  <= '0;
      d1_dvd_q[0]  <= fifo_item_i.offset;
      for (int s = 0; s < DIV1_STEPS; s++) begin
        d1_cls_q[s+1]  <= d1_cls_q[s];
        d1_idx_q[s+1]  <= d1_idx_q[s];
        d1_word_q[s+1] <= d1_word_q[s];
        d1_rem_q[s+1]  <= d1_step[s][31:1];
        d1_dvd_q[s+1]  <= {d1_dvd_q[s][DIV1_STEPS-2:0], d1_step[s][0]};
      end

      a_cls_q  <= a_cls_d;
      a_addr_q <= a_addr_d;
      a_word_q <= d1_word_q[DIV1_STEPS];
      a_num_q  <= d1_rem_q[DIV1_STEPS];

      m_cls_q <= a_cls_q;
      m_num_q <= a_num_q;
      rd_a_q  <= table_q[a_addr_q];
      rd_b_q  <= table_q[a_addr_q + 1'b1];
      if (a_vld_q && a_cls_q == CLS_WRITE) begin
        table_q[a_addr_q] <= a_word_q;
      end

      dd_cls_q <= m_cls_q;
      dd_a_q   <= sa;
      dd_neg_q <= dif[17];
      dd_mag_q <= dif[17] ? 17'(-dif) : dif[16:0];
      dd_num_q <= m_num_q;

      e_cls_q[0] <= dd_cls_q;
      e_a_q[0]   <= dd_a_q;
      e_neg_q[0] <= dd_neg_q;
      e_rem_q[0] <= prod[47:DIV2_STEPS];
      e_dvd_q[0] <= prod[DIV2_STEPS-1:0];
      for (int s = 0; s < DIV2_STEPS; s++) begin
        e_cls_q[s+1] <= e_cls_q[s];
        e_a_q[s+1]   <= e_a_q[s];
        e_neg_q[s+1] <= e_neg_q[s];
        e_rem_q[s+1] <= e_step[s][31:1];
        e_dvd_q[s+1] <= {e_dvd_q[s][DIV2_STEPS-2:0], e_step[s][0]};
      end

      f_cls_q <= e_cls_q[DIV2_STEPS];
      f_a_q   <= e_a_q[DIV2_STEPS];
      f_x_q   <= x;
      f_y_q   <= 18'(x + 19'(WRAP_BIAS));

      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.interp_value  = out_value_q;
  assign out_o.interp_status = out_status_q;

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> fifo_vld_i)
    else $error("Pop from an empty queue.");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q == ST_BLEND && cfg_i.mode == MODE_ANGLE |->
      out_value_q[16] == 1'b0 && out_value_q[15:0] < 16'(FULL_TURN))
    else $error("Blended angle is not reduced.");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(f_vld_q) && $stable(d1_vld_q))
    else $error("Back pipeline moved during a stall.");
`endif

endmodule

@@ tb/uniform_grid_sample_interpolator_test.sv @@
module uniform_grid_sample_interpolator_test;
  import ugsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 2000000;
  localparam int   DRAIN_CYCLES = 80;

  typedef struct packed {
    logic signed [16:0] value;
    logic [1:0]         status;
  } interp_t;

  class interp_scoreboard;
    logic [31:0] start = '0;
    logic [30:0] interval = 31'd1;
    logic [8:0]  count = '0;
    logic [1:0]  mode = MODE_UNSIGNED;
    logic [16:0] fallback = '0;
    logic [15:0] samples [TABLE_DEPTH];
    bit          written [TABLE_DEPTH];
    interp_t     pending_q[$];
    int          errors = 0;

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_START:    start = val;
        REG_INTERVAL: interval = val[30:0];
        REG_COUNT:    count = val[8:0];
        REG_MODE:     mode = val[1:0];
        REG_FALLBACK: fallback = val[16:0];
        default: ;
      endcase
    endfunction

    function int live_count();
      return (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    endfunction

    function longint offset_of(logic [31:0] t);
      logic signed [31:0] diff;
      diff = t - start;
      return longint'(diff);
    endfunction

    function longint sample_at(int k);
      if (mode == MODE_SIGNED) return longint'($signed(samples[k]));
      return longint'(samples[k]);
    endfunction

    // Returns an entry that the query would read before it was written, or -1.
    function int unwritten_entry(logic [31:0] t);
      longint off;
      longint k;
      int cnt;
      off = offset_of(t);
      cnt = live_count();
      if (cnt == 0) return -1;
      if (interval == 0 || off < 0) return written[0] ? -1 : 0;
      k = off / longint'(interval);
      if (k >= cnt - 1) return written[cnt-1] ? -1 : cnt - 1;
      if (!written[k]) return int'(k);
      return written[k+1] ? -1 : int'(k + 1);
    endfunction

    function interp_t interpolate(logic [31:0] t);
      interp_t res;
      longint off, den, k, num, a, b, d, r;
      int cnt;
      off = offset_of(t);
      den = longint'(interval);
      cnt = live_count();
      if (cnt == 0) begin
        res.value = fallback;
        res.status = ST_FALLBACK;
      end else if (den == 0 || off < 0) begin
        res.value = sample_at(0);
        res.status = ST_HOLD;
      end else begin
        k = off / den;
        if (k >= cnt - 1) begin
          res.value = sample_at(cnt - 1);
          res.status = ST_HOLD;
        end else begin
          num = off - k * den;
          a = sample_at(int'(k));
          b = sample_at(int'(k) + 1);
          if (mode == MODE_ANGLE) begin
            d = b - a;
            if (d > HALF_TURN) d -= FULL_TURN;
            if (d < -HALF_TURN) d += FULL_TURN;
            r = (a + (d * num) / den) % FULL_TURN;
            if (r < 0) r += FULL_TURN;
            res.value = r;
          end else begin
            res.value = a + ((b - a) * num) / den;
          end
          res.status = ST_BLEND;
        end
      end
      return res;
    endfunction

    function void note_input(logic cmd, logic [7:0] idx, logic [15:0] word, logic [31:0] t);
      if (cmd == CMD_WRITE) begin
        samples[idx] = word;
        written[idx] = 1'b1;
      end else begin
        pending_q.push_back(interpolate(t));
      end
    endfunction

    function void check_result(logic signed [16:0] value, logic [1:0] status);
      interp_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result beat with no query outstanding: value %0d status %0d", value, status);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (value !== exp_r.value) begin
        $error("interp_value: expected %0d, actual %0d", exp_r.value, value);
        errors++;
      end
      if (status !== exp_r.status) begin
        $error("interp_status: expected %0d, actual %0d", exp_r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ugsi_in_if  in_if ();
  ugsi_out_if out_if ();

  uniform_grid_sample_interpolator i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  interp_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned cycles = 0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("uniform_grid_sample_interpolator verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.interp_value, out_if.interp_status);
      out_if.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic cmd, logic [7:0] idx, logic [15:0] word, logic [31:0] t);
    while (!calm && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.sample_index <= idx;
    in_if.sample_word  <= word;
    in_if.query_time   <= t;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(cmd, idx, word, t);
  endtask

  // Any entry that the query would read is written first, with random content.
  task automatic query(logic [31:0] t);
    int miss;
    miss = sb.unwritten_entry(t);
    while (miss >= 0) begin
      send_beat(CMD_WRITE, 8'(miss), 16'($urandom), 32'($urandom));
      miss = sb.unwritten_entry(t);
    end
    send_beat(CMD_QUERY, 8'($urandom), 16'($urandom), t);
  endtask

  function automatic logic [31:0] grid_time();
    int k;
    logic [31:0] frac;
    if ($urandom_range(9) == 0) return $urandom;
    k = $urandom_range(sb.live_count() + 1);
    frac = (sb.interval == 0) ? $urandom_range(50) : $urandom_range(sb.interval - 1);
    if ($urandom_range(19) == 0) return sb.start - 32'($urandom_range(1, 1000));
    return sb.start + 32'(k) * 32'(sb.interval) + frac;
  endfunction

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] st, logic [30:0] iv, logic [8:0] cnt,
                           logic [1:0] md, logic [16:0] fb);
    settle();
    write_reg(REG_START, st);
    write_reg(REG_INTERVAL, 32'(iv));
    write_reg(REG_COUNT, 32'(cnt));
    write_reg(REG_MODE, 32'(md));
    write_reg(REG_FALLBACK, 32'(fb));
  endtask

  task automatic random_beats(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_beat(CMD_WRITE, 8'($urandom), 16'($urandom), $urandom);
      else
        query(grid_time());
    end
  endtask

  function automatic logic [30:0] pick_interval();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(1000, 100000));
      default: return 31'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [8:0] pick_count();
    case ($urandom_range(5))
      0: return 9'd256;
      1: return 9'($urandom_range(257, 511));
      2: return 9'($urandom_range(0, 1));
      default: return 9'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_WRITE;
    in_if.sample_index <= '0;
    in_if.sample_word  <= '0;
    in_if.query_time   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset gives the fallback value.
    send_beat(CMD_QUERY, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    configure(32'd100, 31'd10, 9'd3, MODE_UNSIGNED, 17'h10000);
    send_beat(CMD_WRITE, 8'd0, 16'h0000, 32'd0);
    send_beat(CMD_WRITE, 8'd1, 16'hFFFF, 32'd0);
    send_beat(CMD_WRITE, 8'd2, 16'h8000, 32'd0);
    send_beat(CMD_WRITE, 8'd255, 16'h7FFF, 32'd0);
    query(32'd99);
    query(32'd100);
    query(32'd105);
    query(32'd119);
    query(32'd120);
    query(32'hFFFF_FFFF);
    query(32'd100 + 32'h8000_0000);
    configure(32'd0, 31'd10, 9'd0, MODE_SIGNED, 17'h0FFFF);
    query(32'd5);
    settle();
    write_reg(REG_COUNT, 32'd3);
    query(32'd5);
    query(32'd15);
    settle();
    write_reg(REG_INTERVAL, 32'd0);
    query(32'd15);
    configure(32'd0, 31'd4, 9'd3, MODE_ANGLE, 17'd0);
    send_beat(CMD_WRITE, 8'd0, 16'd3500, 32'd0);
    send_beat(CMD_WRITE, 8'd1, 16'd100, 32'd0);
    send_beat(CMD_WRITE, 8'd2, 16'd9999, 32'd0);
    query(32'd2);
    query(32'd6);
    query(32'd9);
    configure(32'hFFFF_FFFF, 31'h7FFF_FFFF, 9'h1FF, 2'd3, 17'h1FFFF);
    random_beats(40);

    for (int ph = 0; ph < 8; ph++) begin
      configure($urandom, pick_interval(), pick_count(), 2'($urandom_range(3)),
                17'($urandom));
      calm = (ph == 3);
      random_beats(110);
      calm = 1'b0;
      if (ph == 5) begin
        settle();
        random_beats(20);
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("uniform_grid_sample_interpolator verification clean");
    end else begin
      $display("uniform_grid_sample_interpolator verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ugsi_pkg.sv
src/ugsi_if.sv
src/ugsi_front.sv
src/ugsi_fifo.sv
src/ugsi_back.sv
src/uniform_grid_sample_interpolator.sv
tb/uniform_grid_sample_interpolator_test.sv
